FILE: rtl/period_moving_average_core_defines.svh
// Assertion macros used by the period meter datapath.
`ifndef PERIOD_MOVING_AVERAGE_CORE_DEFINES_SVH
`define PERIOD_MOVING_AVERAGE_CORE_DEFINES_SVH

`ifndef SYNTH
// Same-cycle implication, checked on every rising edge outside reset.
`define PMA_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("period meter check failed");
// Next-cycle implication, checked on every rising edge outside reset.
`define PMA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("period meter check failed");
`else
`define PMA_ASSERT_NOW(label, ante, cons)
`define PMA_ASSERT_NEXT(label, ante, cons)
`endif

`endif

FILE: rtl/pma_pkg.sv
// Package with the shared types and constants of the period meter.
package pma_pkg;

    localparam int WINDOW_MAX_DEF = 64;
    localparam int TIME_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 8;

    localparam int STAMP_W      = 32;
    localparam int PERIOD_OUT_W = 40;
    localparam int WL_W         = 7;
    localparam int DS_W         = 8;
    localparam int CFG_DATA_W   = 8;
    localparam int CFG_IDX_W    = 1;

    localparam logic [WL_W-1:0] WINDOW_RESET     = 7'd10;
    localparam logic [DS_W-1:0] DOWNSAMPLE_RESET = 8'd5;

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DOWNSAMPLE    = 1'd1;

    typedef struct packed {
        logic accept;
        logic update;
        logic load_div;
        logic div_step;
        logic load_out;
    } pma_cmd_t;

    typedef struct packed {
        logic awaiting_first;
        logic div_last;
        logic out_free;
    } pma_status_t;

endpackage

FILE: rtl/period_moving_average_core.sv
// Top level of the moving-average period meter: controller plus datapath.
//
//   channel  direction  handshake            payload
//   in       input      in_valid / in_stall  timestamp
//   out      output     out_valid/out_stall  average_valid, average_period, publish
//   cfg      input      cfg_write            cfg_index, cfg_data
//
// A beat that follows a restart only records its stamp; every other beat
// passes ring update, divider load and division, one quotient bit per cycle.
// Reset is asynchronous and active low; the period ring is never cleared,
// since only entries written since the restart are read.
// A finished result waits in the output register, so the next input beat is
// taken even while that result is stalled downstream.
module period_moving_average_core
#(
    parameter int WINDOW_MAX = pma_pkg::WINDOW_MAX_DEF,
    parameter int TIME_WIDTH = pma_pkg::TIME_WIDTH_DEF,
    parameter int FRAC_BITS  = pma_pkg::FRAC_BITS_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [pma_pkg::STAMP_W-1:0]       timestamp,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic                              average_valid,
    output logic [pma_pkg::PERIOD_OUT_W-1:0]  average_period,
    output logic                              publish,
    input  logic                              cfg_write,
    input  logic [pma_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [pma_pkg::CFG_DATA_W-1:0]    cfg_data
);

    // Commands flow from the controller to the datapath, status flows back.
    pma_pkg::pma_cmd_t    cmd;
    pma_pkg::pma_status_t status;

    // The controller sequences capture, ring update, divider load, the
    // division steps and the hand-off to the output register.
    pma_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    // The datapath holds the configuration, the period ring, the running
    // sum, the publish counter, the divider and the output register.
    pma_dp
    #(
        .WINDOW_MAX (WINDOW_MAX),
        .TIME_WIDTH (TIME_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    )
    u_dp
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .timestamp      (timestamp),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .average_valid  (average_valid),
        .average_period (average_period),
        .publish        (publish)
    );

endmodule

FILE: rtl/pma_ctrl.sv
// Controller state machine of the period meter.
module pma_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  pma_pkg::pma_status_t status,
    output pma_pkg::pma_cmd_t    cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_UPDATE = 3'd1;
    localparam logic [2:0] S_LOAD   = 3'd2;
    localparam logic [2:0] S_DIVIDE = 3'd3;
    localparam logic [2:0] S_DONE   = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        unique case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    // The first beat after a restart only records its stamp.
                    state_next = status.awaiting_first ? S_DONE : S_UPDATE;
                end
            end
            S_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                cmd.load_div = 1'b1;
                state_next   = S_DIVIDE;
            end
            S_DIVIDE:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/pma_dp.sv
// Datapath of the period meter: registers, period ring, running sum and divider.
`include "period_moving_average_core_defines.svh"

module pma_dp
#(
    parameter int WINDOW_MAX = pma_pkg::WINDOW_MAX_DEF,
    parameter int TIME_WIDTH = pma_pkg::TIME_WIDTH_DEF,
    parameter int FRAC_BITS  = pma_pkg::FRAC_BITS_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  pma_pkg::pma_cmd_t                 cmd,
    output pma_pkg::pma_status_t              status,
    input  logic [pma_pkg::STAMP_W-1:0]       timestamp,
    input  logic                              cfg_write,
    input  logic [pma_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [pma_pkg::CFG_DATA_W-1:0]    cfg_data,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic                              average_valid,
    output logic [pma_pkg::PERIOD_OUT_W-1:0]  average_period,
    output logic                              publish
);

    localparam int CNT_W    = $clog2(WINDOW_MAX + 1);
    localparam int SLOT_W   = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int SUM_W    = TIME_WIDTH + $clog2(WINDOW_MAX);
    localparam int DIV_W    = SUM_W + FRAC_BITS;
    localparam int DCNT_W   = $clog2(DIV_W);
    localparam int WL_CMP_W = (CNT_W > pma_pkg::WL_W) ? CNT_W : pma_pkg::WL_W;

    // Configuration registers.
    logic [pma_pkg::WL_W-1:0] window_length_reg;
    logic [pma_pkg::DS_W-1:0] downsample_reg;

    // Measurement state.
    logic [TIME_WIDTH-1:0] last_stamp_reg;
    logic                  awaiting_reg;
    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;
    logic [SLOT_W-1:0]     slot_reg;
    logic [SLOT_W-1:0]     slot_next;
    logic [SUM_W-1:0]      sum_reg;
    logic [SUM_W-1:0]      sum_next;
    logic [pma_pkg::DS_W-1:0] pub_count_reg;
    logic [pma_pkg::DS_W-1:0] pub_count_next;

    // Per-item working registers.
    logic [TIME_WIDTH-1:0] period_reg;
    logic                  first_reg;
    logic                  pub_reg;
    logic                  pub_next;

    // Ring storage.
    logic [TIME_WIDTH-1:0] ring [WINDOW_MAX];
    logic [TIME_WIDTH-1:0] rd_data_reg;
    logic [SLOT_W-1:0]     rd_addr;
    logic [SLOT_W-1:0]     wr_addr;
    logic                  ring_we;

    // Divider.
    logic [DIV_W-1:0]  quot_reg;
    logic [CNT_W-1:0]  rem_reg;
    logic [DCNT_W-1:0] div_cnt_reg;
    logic [CNT_W:0]    trial;
    logic              trial_ge;

    // Output register.
    logic                             out_valid_reg;
    logic                             avg_valid_reg;
    logic [pma_pkg::PERIOD_OUT_W-1:0] avg_period_reg;
    logic                             publish_reg;

    logic [TIME_WIDTH-1:0] stamp_ext;
    logic [WL_CMP_W-1:0]   wl_ext;
    logic [CNT_W-1:0]      win;
    logic [SLOT_W-1:0]     slot_eff;
    logic [CNT_W-1:0]      slot_inc;
    logic                  full;
    logic                  restart;
    logic                  out_free;

    assign stamp_ext = TIME_WIDTH'(timestamp);
    assign restart   = cfg_write && (cfg_index == pma_pkg::REG_WINDOW_LENGTH);

    // Window length clamped to the range 1 .. WINDOW_MAX.
    assign wl_ext = WL_CMP_W'(window_length_reg);
    always_comb
    begin
        if (wl_ext == '0)
        begin
            win = CNT_W'(1);
        end
        else if (wl_ext > WL_CMP_W'(WINDOW_MAX))
        begin
            win = CNT_W'(WINDOW_MAX);
        end
        else
        begin
            win = CNT_W'(wl_ext);
        end
    end

    assign full     = (count_reg >= win);
    assign slot_eff = (CNT_W'(slot_reg) >= win) ? '0 : slot_reg;
    assign slot_inc = CNT_W'(slot_eff) + CNT_W'(1);
    assign rd_addr  = slot_eff;
    assign wr_addr  = full ? slot_eff : SLOT_W'(count_reg);
    assign ring_we  = cmd.update;

    always_comb
    begin
        count_next = count_reg;
        slot_next  = slot_reg;
        if (full)
        begin
            sum_next  = sum_reg + SUM_W'(period_reg) - SUM_W'(rd_data_reg);
            slot_next = (slot_inc >= win) ? '0 : SLOT_W'(slot_inc);
        end
        else
        begin
            sum_next   = sum_reg + SUM_W'(period_reg);
            count_next = count_reg + CNT_W'(1);
        end
    end

    always_comb
    begin
        pub_count_next = pub_count_reg + pma_pkg::DS_W'(1);
        pub_next       = (pub_count_next >= downsample_reg);
        if (pub_next)
        begin
            pub_count_next = '0;
        end
    end

    // Restoring division, one quotient bit per step.
    assign trial    = {rem_reg, quot_reg[DIV_W-1]};
    assign trial_ge = (trial >= {1'b0, count_reg});

    assign out_free = !out_valid_reg || !out_stall;

    assign status.awaiting_first = awaiting_reg;
    assign status.div_last       = (div_cnt_reg == DCNT_W'(DIV_W - 1));
    assign status.out_free       = out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_length_reg <= pma_pkg::WINDOW_RESET;
            downsample_reg    <= pma_pkg::DOWNSAMPLE_RESET;
            last_stamp_reg    <= '0;
            awaiting_reg      <= 1'b1;
            count_reg         <= '0;
            slot_reg          <= '0;
            sum_reg           <= '0;
            pub_count_reg     <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_index)
                    pma_pkg::REG_WINDOW_LENGTH:
                    begin
                        window_length_reg <= pma_pkg::WL_W'(cfg_data);
                    end
                    pma_pkg::REG_DOWNSAMPLE:
                    begin
                        downsample_reg <= cfg_data;
                    end
                    default:
                    begin
                    end
                endcase
            end
            if (restart)
            begin
                awaiting_reg <= 1'b1;
                count_reg    <= '0;
                slot_reg     <= '0;
                sum_reg      <= '0;
            end
            else
            begin
                if (cmd.accept)
                begin
                    last_stamp_reg <= stamp_ext;
                    awaiting_reg   <= 1'b0;
                end
                if (cmd.update)
                begin
                    count_reg     <= count_next;
                    slot_reg      <= slot_next;
                    sum_reg       <= sum_next;
                    pub_count_reg <= pub_count_next;
                end
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            period_reg <= stamp_ext - last_stamp_reg;
            first_reg  <= awaiting_reg;
        end
        if (cmd.update)
        begin
            pub_reg <= pub_next;
        end
        if (cmd.load_div)
        begin
            quot_reg    <= DIV_W'(sum_reg) << FRAC_BITS;
            rem_reg     <= '0;
            div_cnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            quot_reg    <= {quot_reg[DIV_W-2:0], trial_ge};
            rem_reg     <= trial_ge ? CNT_W'(trial - {1'b0, count_reg}) : CNT_W'(trial);
            div_cnt_reg <= div_cnt_reg + DCNT_W'(1);
        end
        if (cmd.load_out)
        begin
            avg_valid_reg  <= !first_reg;
            avg_period_reg <= first_reg ? '0 : pma_pkg::PERIOD_OUT_W'(quot_reg);
            publish_reg    <= first_reg ? 1'b0 : pub_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ring_we)
        begin
            ring[wr_addr] <= period_reg;
        end
        rd_data_reg <= ring[rd_addr];
    end

    assign out_valid      = out_valid_reg;
    assign average_valid  = avg_valid_reg;
    assign average_period = avg_period_reg;
    assign publish        = publish_reg;

    `PMA_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= CNT_W'(WINDOW_MAX))
    `PMA_ASSERT_NOW(a_rem_below_divisor, cmd.div_step, rem_reg < count_reg)
    `PMA_ASSERT_NEXT(a_load_shows_beat, cmd.load_out, out_valid_reg)
    `PMA_ASSERT_NOW(a_divide_nonzero, cmd.load_div, count_reg != '0)

endmodule
